>>> hw/rtl/pfa_pkg.sv
// shared constants, codes and beat types of the paged frame allocator
package pfa_pkg;

   // default sizes
   localparam int FRAME_COUNT_DEF       = 64;
   localparam int PROCESS_COUNT_DEF     = 4;
   localparam int PAGES_PER_PROCESS_DEF = 16;

   // command codes on the request side
   localparam logic [1:0] CMD_RESIZE = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;

   // status codes on the response side
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_OOM       = 3'd1;
   localparam logic [2:0] ST_NO_PAGES  = 3'd2;
   localparam logic [2:0] ST_TOO_LARGE = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   // work kinds handed from the front to the back
   localparam logic [1:0] KIND_RESIZE    = 2'd0;
   localparam logic [1:0] KIND_LOOKUP    = 2'd1;
   localparam logic [1:0] KIND_TOO_LARGE = 2'd2;

   // classified request beat
   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] process_id;
      logic [4:0] target_pages;
      logic [5:0] frame;
   } item_type;

   // response beat
   typedef struct packed {
      logic [2:0] status;
      logic       frame_valid;
      logic [3:0] page_index;
      logic [5:0] frame_number;
      logic       last;
   } result_type;

endpackage

>>> hw/rtl/paged_frame_allocator.sv
// Paged frame allocator top level. Requests are queued two deep and run one at a time.
// A resize that grows scans the frame bitmap upward for free frames, and a shrink or
// lookup steps through the pages of the process. Results leave through a two-entry
// queue; the back end waits when it is full. After reset a clearing pass marks every
// frame free while full stays high.
module paged_frame_allocator #(
   parameter int FRAME_COUNT       = pfa_pkg::FRAME_COUNT_DEF,
   parameter int PROCESS_COUNT     = pfa_pkg::PROCESS_COUNT_DEF,
   parameter int PAGES_PER_PROCESS = pfa_pkg::PAGES_PER_PROCESS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [1:0] req_cmd,
   input  logic [1:0] req_process_id,
   input  logic [4:0] req_target_pages,
   input  logic [5:0] req_frame,
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_status,
   output logic       rsp_frame_valid,
   output logic [3:0] rsp_page_index,
   output logic [5:0] rsp_frame_number,
   output logic       rsp_last
);

   logic                item_valid, item_pop, clearing;
   pfa_pkg::item_type   item;
   logic                res_push, res_full;
   pfa_pkg::result_type res_data, head;

   // request intake
   pfa_front #(
      .PROCESS_COUNT(PROCESS_COUNT),
      .PAGES_PER_PROCESS(PAGES_PER_PROCESS)
   ) u_front (
      .clock, .reset, .push, .full,
      .req_cmd, .req_process_id, .req_target_pages, .req_frame,
      .hold(clearing), .item_valid, .item, .item_pop
   );

   // sequencer and storage
   pfa_back #(
      .FRAME_COUNT(FRAME_COUNT),
      .PROCESS_COUNT(PROCESS_COUNT),
      .PAGES_PER_PROCESS(PAGES_PER_PROCESS)
   ) u_back (
      .clock, .reset, .item_valid, .item, .item_pop, .clearing,
      .rsp_push(res_push), .rsp_data(res_data), .rsp_full(res_full)
   );

   // response queue
   pfa_rsp_fifo u_rsp (
      .clock, .reset, .wr_en(res_push), .wr_data(res_data), .full(res_full),
      .pop, .empty, .head
   );

   assign rsp_status       = head.status;
   assign rsp_frame_valid  = head.frame_valid;
   assign rsp_page_index   = head.page_index;
   assign rsp_frame_number = head.frame_number;
   assign rsp_last         = head.last;

endmodule

>>> hw/rtl/pfa_front.sv
// request intake: classifies beats and queues work for the back end
module pfa_front #(
   parameter int PROCESS_COUNT     = pfa_pkg::PROCESS_COUNT_DEF,
   parameter int PAGES_PER_PROCESS = pfa_pkg::PAGES_PER_PROCESS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        req_cmd,
   input  logic [1:0]        req_process_id,
   input  logic [4:0]        req_target_pages,
   input  logic [5:0]        req_frame,
   input  logic              hold,
   output logic              item_valid,
   output pfa_pkg::item_type item,
   input  logic              item_pop
);

   pfa_pkg::item_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   pfa_pkg::item_type cls;
   logic              keep;
   logic              do_wr, do_rd;

   // classify the incoming beat
   always_comb begin
      cls.process_id   = req_process_id;
      cls.target_pages = req_target_pages;
      cls.frame        = req_frame;
      cls.kind         = pfa_pkg::KIND_LOOKUP;
      keep             = 1'b0;
      case (req_cmd)
         pfa_pkg::CMD_RESIZE: begin
            keep = 1'b1;
            if (32'(req_target_pages) > PAGES_PER_PROCESS) begin
               cls.kind = pfa_pkg::KIND_TOO_LARGE;
            end else begin
               cls.kind = pfa_pkg::KIND_RESIZE;
            end
         end
         pfa_pkg::CMD_LOOKUP: begin
            keep     = 1'b1;
            cls.kind = pfa_pkg::KIND_LOOKUP;
         end
         default: keep = 1'b0;
      endcase
      if (32'(req_process_id) >= PROCESS_COUNT) begin
         keep = 1'b0;
      end
   end

   // queue control
   assign full       = (cnt_ff == 2'd2) | hold;
   assign do_wr      = push & ~full & keep;
   assign item_valid = (cnt_ff != 2'd0);
   assign do_rd      = item_pop & item_valid;
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> hw/rtl/pfa_back.sv
// back end: frame bitmap, page tables and the allocate, free and lookup sequencer
module pfa_back #(
   parameter int FRAME_COUNT       = pfa_pkg::FRAME_COUNT_DEF,
   parameter int PROCESS_COUNT     = pfa_pkg::PROCESS_COUNT_DEF,
   parameter int PAGES_PER_PROCESS = pfa_pkg::PAGES_PER_PROCESS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  pfa_pkg::item_type   item,
   output logic                item_pop,
   output logic                clearing,
   output logic                rsp_push,
   output pfa_pkg::result_type rsp_data,
   input  logic                rsp_full
);

   localparam int FW        = $clog2(FRAME_COUNT);
   localparam int FCW       = $clog2(FRAME_COUNT + 1);
   localparam int TDEPTH    = PROCESS_COUNT * PAGES_PER_PROCESS;
   localparam int TW        = (TDEPTH > 2) ? $clog2(TDEPTH) : 1;
   localparam int CPW       = (PROCESS_COUNT > 2) ? $clog2(PROCESS_COUNT) : 1;
   localparam int CLEAR_LEN = (FRAME_COUNT > PROCESS_COUNT) ? FRAME_COUNT : PROCESS_COUNT;
   localparam int CLW       = $clog2(CLEAR_LEN);
   localparam int CW        = (FW > 6) ? FW : 6;

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_LOAD     = 4'd2;
   localparam logic [3:0] S_DISPATCH = 4'd3;
   localparam logic [3:0] S_A_RD     = 4'd4;
   localparam logic [3:0] S_A_CHK    = 4'd5;
   localparam logic [3:0] S_F_RD     = 4'd6;
   localparam logic [3:0] S_F_CHK    = 4'd7;
   localparam logic [3:0] S_L_RD     = 4'd8;
   localparam logic [3:0] S_L_CHK    = 4'd9;

   // memories
   logic          used_mem  [FRAME_COUNT];
   logic [FW-1:0] table_mem [TDEPTH];
   logic [4:0]    count_mem [PROCESS_COUNT];

   logic [3:0]     state_ff, state_in;
   logic [CLW-1:0] clr_ff, clr_in;
   logic [FCW-1:0] free_ff, free_in;
   logic [1:0]     kind_ff, kind_in;
   logic [1:0]     pid_ff, pid_in;
   logic [4:0]     target_ff, target_in;
   logic [5:0]     frame_ff, frame_in;
   logic [4:0]     page_ff, page_in;
   logic [FW-1:0]  addr_ff, addr_in;

   logic           used_rd_ff;
   logic [FW-1:0]  table_rd_ff;
   logic [4:0]     count_rd_ff;

   logic           used_we, used_wdata;
   logic [FW-1:0]  used_waddr;
   logic           table_we;
   logic [TW-1:0]  table_addr;
   logic           count_we;
   logic [CPW-1:0] count_waddr;
   logic [4:0]     count_wdata;
   logic [4:0]     need;

   assign table_addr = TW'(pid_ff) * TW'(PAGES_PER_PROCESS) + TW'(page_ff);
   assign need       = target_ff - count_rd_ff;
   assign clearing   = (state_ff == S_CLEAR);
   assign item_pop   = (state_ff == S_IDLE) & item_valid;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      free_in     = free_ff;
      kind_in     = kind_ff;
      pid_in      = pid_ff;
      target_in   = target_ff;
      frame_in    = frame_ff;
      page_in     = page_ff;
      addr_in     = addr_ff;
      used_we     = 1'b0;
      used_wdata  = 1'b0;
      used_waddr  = addr_ff;
      table_we    = 1'b0;
      count_we    = 1'b0;
      count_waddr = CPW'(pid_ff);
      count_wdata = target_ff;
      rsp_push    = 1'b0;
      rsp_data    = '{status: pfa_pkg::ST_OK, frame_valid: 1'b0, page_index: 4'd0,
                      frame_number: 6'd0, last: 1'b1};
      case (state_ff)
         S_CLEAR: begin
            used_waddr  = FW'(clr_ff);
            used_we     = (32'(clr_ff) < FRAME_COUNT);
            count_waddr = CPW'(clr_ff);
            count_we    = (32'(clr_ff) < PROCESS_COUNT);
            count_wdata = 5'd0;
            free_in     = FCW'(FRAME_COUNT);
            clr_in      = clr_ff + 1'b1;
            if (32'(clr_ff) == CLEAR_LEN - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (item_valid) begin
               kind_in   = item.kind;
               pid_in    = item.process_id;
               target_in = item.target_pages;
               frame_in  = item.frame;
               state_in  = S_LOAD;
            end
         end
         S_LOAD: state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (!rsp_full) begin
               state_in = S_IDLE;
               case (kind_ff)
                  pfa_pkg::KIND_TOO_LARGE: begin
                     rsp_push        = 1'b1;
                     rsp_data.status = pfa_pkg::ST_TOO_LARGE;
                  end
                  pfa_pkg::KIND_LOOKUP: begin
                     if (count_rd_ff == 5'd0) begin
                        rsp_push        = 1'b1;
                        rsp_data.status = pfa_pkg::ST_NOT_FOUND;
                     end else begin
                        page_in  = 5'd0;
                        state_in = S_L_RD;
                     end
                  end
                  default: begin
                     if (target_ff > count_rd_ff) begin
                        if (32'(free_ff) < 32'(need)) begin
                           rsp_push        = 1'b1;
                           rsp_data.status = pfa_pkg::ST_OOM;
                        end else begin
                           page_in  = count_rd_ff;
                           addr_in  = '0;
                           state_in = S_A_RD;
                        end
                     end else if (count_rd_ff == 5'd0) begin
                        rsp_push        = 1'b1;
                        rsp_data.status = pfa_pkg::ST_NO_PAGES;
                     end else if (target_ff == count_rd_ff) begin
                        rsp_push = 1'b1;
                     end else begin
                        page_in  = count_rd_ff - 5'd1;
                        state_in = S_F_RD;
                     end
                  end
               endcase
            end
         end
         S_A_RD: state_in = S_A_CHK;
         S_A_CHK: begin
            if (used_rd_ff) begin
               addr_in  = addr_ff + 1'b1;
               state_in = S_A_RD;
            end else if (!rsp_full) begin
               used_we    = 1'b1;
               used_wdata = 1'b1;
               table_we   = 1'b1;
               free_in    = free_ff - 1'b1;
               rsp_push   = 1'b1;
               rsp_data   = '{status: pfa_pkg::ST_OK, frame_valid: 1'b1,
                              page_index: 4'(page_ff), frame_number: 6'(addr_ff),
                              last: (page_ff + 5'd1 == target_ff)};
               if (page_ff + 5'd1 == target_ff) begin
                  count_we = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  page_in  = page_ff + 5'd1;
                  addr_in  = addr_ff + 1'b1;
                  state_in = S_A_RD;
               end
            end
         end
         S_F_RD: state_in = S_F_CHK;
         S_F_CHK: begin
            if (!rsp_full) begin
               used_waddr = table_rd_ff;
               used_we    = (32'(table_rd_ff) < FRAME_COUNT);
               free_in    = free_ff + FCW'(used_we);
               rsp_push   = 1'b1;
               rsp_data   = '{status: pfa_pkg::ST_OK, frame_valid: 1'b1,
                              page_index: 4'(page_ff), frame_number: 6'(table_rd_ff),
                              last: (page_ff == target_ff)};
               if (page_ff == target_ff) begin
                  count_we = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  page_in  = page_ff - 5'd1;
                  state_in = S_F_RD;
               end
            end
         end
         S_L_RD: state_in = S_L_CHK;
         S_L_CHK: begin
            if (!rsp_full) begin
               if (CW'(table_rd_ff) == CW'(frame_ff)) begin
                  rsp_push = 1'b1;
                  rsp_data = '{status: pfa_pkg::ST_OK, frame_valid: 1'b1,
                               page_index: 4'(page_ff), frame_number: frame_ff, last: 1'b1};
                  state_in = S_IDLE;
               end else if (page_ff + 5'd1 == count_rd_ff) begin
                  rsp_push        = 1'b1;
                  rsp_data.status = pfa_pkg::ST_NOT_FOUND;
                  state_in        = S_IDLE;
               end else begin
                  page_in  = page_ff + 5'd1;
                  state_in = S_L_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         free_ff  <= FCW'(FRAME_COUNT);
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         free_ff  <= free_in;
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      pid_ff    <= pid_in;
      target_ff <= target_in;
      frame_ff  <= frame_in;
      page_ff   <= page_in;
      addr_ff   <= addr_in;
   end

   // frame bitmap
   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_waddr] <= used_wdata;
      end
      used_rd_ff <= used_mem[addr_ff];
   end

   // page tables
   always_ff @(posedge clock) begin
      if (table_we) begin
         table_mem[table_addr] <= addr_ff;
      end
      table_rd_ff <= table_mem[table_addr];
   end

   // page counts
   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[count_waddr] <= count_wdata;
      end
      count_rd_ff <= count_mem[CPW'(pid_ff)];
   end

   // checks
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      32'(free_ff) <= FRAME_COUNT)
      else $error("free frame count above capacity");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("response beat pushed into full queue");
   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && state_ff == S_A_CHK) |-> !used_rd_ff)
      else $error("allocated a frame already in use");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_we && state_ff != S_CLEAR) |-> 32'(count_wdata) <= PAGES_PER_PROCESS)
      else $error("page count above table size");
   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_CHK && rsp_push) |-> free_ff != '0)
      else $error("allocation with no free frame");

endmodule

>>> hw/rtl/pfa_rsp_fifo.sv
// two-entry response queue between the back end and the result ports
module pfa_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  pfa_pkg::result_type wr_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output pfa_pkg::result_type head
);

   pfa_pkg::result_type q_ff [2];
   logic                wr_ptr_ff, rd_ptr_ff;
   logic [1:0]          cnt_ff, cnt_in;
   logic                do_wr, do_rd;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign do_wr = wr_en & ~full;
   assign do_rd = pop & ~empty;
   assign head  = q_ff[rd_ptr_ff];
   assign cnt_in = cnt_ff + 2'(do_wr) - 2'(do_rd);

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ do_wr;
         rd_ptr_ff <= rd_ptr_ff ^ do_rd;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         q_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> tb/paged_frame_allocator_tb.sv
// self-checking testbench of the paged frame allocator
module paged_frame_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAMES = pfa_pkg::FRAME_COUNT_DEF;
   localparam int PROCS = pfa_pkg::PROCESS_COUNT_DEF;
   localparam int PAGES = pfa_pkg::PAGES_PER_PROCESS_DEF;
   localparam logic [1:0] CMD_RSVD2 = 2'd2;
   localparam logic [1:0] CMD_RSVD3 = 2'd3;

   // predicted allocator with its queue of expected response beats
   class frame_scoreboard;
      bit frame_used [FRAMES];
      logic [5:0] page_frame [PROCS][PAGES];
      int pages_in_use [PROCS];
      pfa_pkg::result_type pending [$];
      int errors;
      int beats_checked;

      function void add(logic [2:0] st, logic v, logic [3:0] pg, logic [5:0] fr, logic l);
         pfa_pkg::result_type r;
         r.status = st; r.frame_valid = v; r.page_index = pg;
         r.frame_number = fr; r.last = l;
         pending.push_back(r);
      endfunction

      // predict the beats caused by one accepted request
      function void note_request(logic [1:0] cmd, logic [1:0] pid, logic [4:0] tgt,
                                 logic [5:0] fr);
         int cur, nfree, f, t;
         bit hit;
         t = int'(tgt);
         if (cmd == CMD_RSVD2 || cmd == CMD_RSVD3 || int'(pid) >= PROCS) return;
         cur = pages_in_use[pid];
         if (cmd == pfa_pkg::CMD_LOOKUP) begin
            hit = 0;
            for (int p = 0; p < cur && !hit; p++)
               if (page_frame[pid][p] == fr) begin
                  add(pfa_pkg::ST_OK, 1'b1, p[3:0], fr, 1'b1);
                  hit = 1;
               end
            if (!hit) add(pfa_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
            return;
         end
         if (t > PAGES) begin
            add(pfa_pkg::ST_TOO_LARGE, 0, 0, 0, 1);
            return;
         end
         if (t > cur) begin
            nfree = 0;
            foreach (frame_used[i]) if (!frame_used[i]) nfree++;
            if (nfree < t - cur) begin
               add(pfa_pkg::ST_OOM, 0, 0, 0, 1);
               return;
            end
            for (int p = cur; p < t; p++) begin
               f = 0;
               while (frame_used[f]) f++;
               frame_used[f] = 1;
               page_frame[pid][p] = f[5:0];
               add(pfa_pkg::ST_OK, 1, p[3:0], f[5:0], p + 1 == t);
            end
            pages_in_use[pid] = t;
            return;
         end
         if (cur == 0) begin
            add(pfa_pkg::ST_NO_PAGES, 0, 0, 0, 1);
            return;
         end
         if (t == cur) begin
            add(pfa_pkg::ST_OK, 0, 0, 0, 1);
            return;
         end
         for (int p = cur - 1; p >= t; p--) begin
            frame_used[page_frame[pid][p]] = 0;
            add(pfa_pkg::ST_OK, 1, p[3:0], page_frame[pid][p], p == t);
         end
         pages_in_use[pid] = t;
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // compare one accepted response beat with the oldest prediction
      task check_beat(pfa_pkg::result_type got);
         pfa_pkg::result_type w;
         if (pending.size() == 0) begin
            report($sformatf("unexpected beat %p", got));
            return;
         end
         w = pending.pop_front();
         beats_checked++;
         if (got.status !== w.status)
            report($sformatf("status %0d want %0d", got.status, w.status));
         if (got.frame_valid !== w.frame_valid)
            report($sformatf("frame_valid %0d want %0d", got.frame_valid, w.frame_valid));
         if (got.page_index !== w.page_index)
            report($sformatf("page_index %0d want %0d", got.page_index, w.page_index));
         if (got.frame_number !== w.frame_number)
            report($sformatf("frame_number %0d want %0d", got.frame_number, w.frame_number));
         if (got.last !== w.last)
            report($sformatf("last %0d want %0d", got.last, w.last));
      endtask
   endclass

   logic clock = 0, reset = 1, push = 0, pop = 0;
   logic [1:0] req_cmd = 0, req_process_id = 0;
   logic [4:0] req_target_pages = 0;
   logic [5:0] req_frame = 0;
   logic full, empty, rsp_frame_valid, rsp_last;
   logic [2:0] rsp_status;
   logic [3:0] rsp_page_index;
   logic [5:0] rsp_frame_number;

   frame_scoreboard sb;
   int requests_sent;
   bit sending_done;

   paged_frame_allocator i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // send one request beat after a random gap
   task automatic send_request(logic [1:0] cmd, logic [1:0] pid, logic [4:0] tgt,
                               logic [5:0] fr);
      int gap;
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1; req_cmd <= cmd; req_process_id <= pid;
      req_target_pages <= tgt; req_frame <= fr;
      do @(posedge clock); while (full);
      sb.note_request(cmd, pid, tgt, fr);
      requests_sent++;
   endtask

   // response side: random stalls, checking on every accepted beat
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 19);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         sb.check_beat('{rsp_status, rsp_frame_valid, rsp_page_index,
                         rsp_frame_number, rsp_last});
      end
   end

   initial begin
      int k;
      logic [1:0] pid;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 0;
      // directed: empty shrink, lookups, extremes, every frame in use
      send_request(pfa_pkg::CMD_RESIZE, 0, 0, 0);
      send_request(pfa_pkg::CMD_LOOKUP, 0, 0, 6'd63);
      send_request(pfa_pkg::CMD_RESIZE, 0, 5'd31, 0);
      send_request(pfa_pkg::CMD_RESIZE, 1, 5'd17, 0);
      send_request(pfa_pkg::CMD_RESIZE, 0, 5'd16, 0);
      send_request(pfa_pkg::CMD_RESIZE, 1, 5'd16, 0);
      send_request(pfa_pkg::CMD_RESIZE, 2, 5'd16, 0);
      send_request(pfa_pkg::CMD_RESIZE, 3, 5'd16, 0);
      send_request(pfa_pkg::CMD_LOOKUP, 3, 0, 6'd63);
      send_request(pfa_pkg::CMD_LOOKUP, 0, 0, 6'd0);
      send_request(pfa_pkg::CMD_LOOKUP, 2, 0, 6'd0);
      send_request(pfa_pkg::CMD_RESIZE, 3, 5'd16, 0);
      send_request(pfa_pkg::CMD_RESIZE, 1, 5'd3, 0);
      send_request(pfa_pkg::CMD_RESIZE, 0, 5'd1, 0);
      send_request(pfa_pkg::CMD_RESIZE, 3, 5'd16, 0);
      send_request(pfa_pkg::CMD_RESIZE, 0, 5'd16, 0);
      send_request(CMD_RSVD2, 2, 5'd31, 6'd63);
      send_request(CMD_RSVD3, 3, 5'd31, 6'd63);
      send_request(pfa_pkg::CMD_RESIZE, 1, 5'd0, 0);
      send_request(pfa_pkg::CMD_RESIZE, 2, 5'd0, 0);
      send_request(pfa_pkg::CMD_RESIZE, 3, 5'd0, 0);
      send_request(pfa_pkg::CMD_RESIZE, 0, 5'd0, 0);
      // random: mostly resizes of moderate size and lookups of likely frames
      for (int i = 0; i < 420; i++) begin
         pid = 2'($urandom_range(0, 3));
         k = $urandom_range(0, 99);
         if (k < 50)
            send_request(pfa_pkg::CMD_RESIZE, pid, 5'($urandom_range(0, 16)),
                         6'($urandom));
         else if (k < 55)
            send_request(pfa_pkg::CMD_RESIZE, pid, 5'($urandom_range(17, 31)),
                         6'($urandom));
         else if (k < 90)
            send_request(pfa_pkg::CMD_LOOKUP, pid, 5'($urandom),
                         6'($urandom_range(0, 40)));
         else if (k < 95)
            send_request(pfa_pkg::CMD_LOOKUP, pid, 5'($urandom), 6'($urandom));
         else
            send_request(2'($urandom_range(2, 3)), pid, 5'($urandom), 6'($urandom));
      end
      push <= 1'b0;
      sending_done = 1;
   end

   // end of run once every prediction has arrived
   initial begin
      wait (sending_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("%0d requests sent, %0d response beats checked", requests_sent,
               sb.beats_checked);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("simulation failed");
      $finish;
   end
endmodule

>>> paged_frame_allocator.f
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_front.sv
hw/rtl/pfa_back.sv
hw/rtl/pfa_rsp_fifo.sv
hw/rtl/paged_frame_allocator.sv
tb/paged_frame_allocator_tb.sv
